[sv/dag_pkg.sv]
// Shared types, codes and constant functions of the distance attenuation gain block.
package dag_pkg;

	// distance model codes
	typedef enum logic [1:0] {
		MODEL_NONE    = 2'd0,
		MODEL_LINEAR  = 2'd1,
		MODEL_INVERSE = 2'd2,
		MODEL_EXP     = 2'd3
	} dag_model_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_MODEL   = 2'd0,
		REG_REF     = 2'd1,
		REG_MAX     = 2'd2,
		REG_ROLLOFF = 2'd3
	} dag_reg_t;

	// fraction bits of the log2 value
	localparam int LFRAC = 16;

	// exponential path: 2 normalize, 16 log, 1 diff, 1 scale, 16 exp, 1 shift
	localparam int EXP_LAT = 2 + LFRAC + 1 + 1 + LFRAC + 1;

	// flags that ride along with the main divider
	typedef struct packed {
		logic past;
		logic unity;
		logic zero;
	} dag_flags_t;

	// integer square root, bit by bit (elaboration only)
	function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		v = v_in;
		r = '0;
		b = 64'h4000_0000_0000_0000;
		for (int i = 0; i < 32; i++) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Q.30 value of 2^-(2^-(j+1)), by repeated square roots
	function automatic logic [29:0] exp_const(input int j);
		logic [63:0] c;
		c = isqrt64(64'd1 << 59);
		for (int i = 0; i < LFRAC; i++) begin
			if (i < j) begin
				c = isqrt64(c << 30);
			end
		end
		return c[29:0];
	endfunction

endpackage

[sv/dag_cfg_if.sv]
// Configuration write channel: register index and write data.
interface dag_cfg_if #(parameter int DATA_W = 24);
	logic              valid;
	logic              ready;
	logic [1:0]        index;
	logic [DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[sv/dag_dist_if.sv]
// Distance request channel.
interface dag_dist_if #(parameter int DIST_W = 24);
	logic              valid;
	logic              ready;
	logic [DIST_W-1:0] distance;

	modport source (output valid, output distance, input ready);
	modport sink (input valid, input distance, output ready);
endinterface

[sv/dag_gain_if.sv]
// Gain result channel.
interface dag_gain_if;
	logic        valid;
	logic        ready;
	logic [15:0] gain;

	modport source (output valid, output gain, input ready);
	modport sink (input valid, input gain, output ready);
endinterface

[sv/distance_attenuation_gain.sv]
// Distance attenuation gain: top level with config registers and model pipeline.
//
//  channel  dir  payload               handshake
//  cfg      in   index[1:0], data      valid/ready, always ready
//  sample   in   distance[DW-1:0]      valid/ready
//  result   out  gain[15:0]            valid/ready
//
// One request is accepted per cycle while result is not stalled.
// Depth is set by the exponential path: 16 log2 square steps per lane and
// 16 exp2 multiply steps; linear and inverse go through a GAIN_FRAC-stage
// divider and are delayed to line up. Reset clears valids and config registers.
// A stall on result freezes the whole pipeline; bubbles are not squeezed.
module distance_attenuation_gain #(
	parameter int DIST_WIDTH = 24,
	parameter int GAIN_FRAC  = 15,
	parameter int MIN_REF    = 1
) (
	input logic        clk,
	input logic        arst_n,
	dag_cfg_if.sink    cfg,
	dag_dist_if.sink   sample,
	dag_gain_if.source result
);
	import dag_pkg::*;

	localparam int DW  = DIST_WIDTH;
	localparam int GF  = GAIN_FRAC;
	localparam int GW  = GF + 1;
	localparam int MW  = DW + 16;
	localparam int AW  = DW + 17;
	localparam int BW  = DW + 2;
	localparam int DLY = EXP_LAT - (GF + 3);
	localparam int NV  = EXP_LAT + 2;
	localparam int XW  = GW + 16;
	localparam logic [GW-1:0] GONE = {1'b1, {GF{1'b0}}};
	localparam logic [DW-1:0] MINR = DW'(MIN_REF);

	dag_model_t    model_q;
	logic [DW-1:0] ref_q;
	logic [DW-1:0] max_q;
	logic [15:0]   roll_q;

	logic          en;
	logic [NV-1:0] vld_q;

	logic [DW-1:0] r_c;
	logic [DW-1:0] d_c;
	logic [DW-1:0] r_s1, d_s1, excess_s1, span_s1, left_s1;
	logic          past_s1;

	logic [MW-1:0] m_s2;
	logic [DW-1:0] r_s2, span_s2, left_s2;
	logic          past_s2;

	logic          is_lin;
	logic [AW-1:0] rq, q_lin, m_ext;
	logic [AW-1:0] a_num_s3, a_den_s3;
	logic [BW-1:0] b_num;
	logic [BW-1:0] b_num_s3, b_den_s3;
	logic          tail_s3;
	dag_flags_t    flags_c, flags_s3;

	logic [GF-1:0] qa, tb;
	dag_flags_t    flags_d;
	logic          tail_d;

	logic [GW-1:0]    g_pre;
	logic [GW+GF-1:0] tail_prod;
	logic [GW-1:0]    g_tail;
	logic [GW-1:0]    g_div;
	logic [GW-1:0]    g_d1;
	logic             use_exp_d1;

	logic [GW-1:0] g_dl_q   [DLY];
	logic          exp_dl_q [DLY];

	logic [GW-1:0] g_exp;
	logic [GW-1:0] gain_q;
	logic [XW-1:0] gain_x;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_q <= MODEL_INVERSE;
			ref_q   <= DW'(256);
			max_q   <= DW'(24'hFF_FFFF);
			roll_q  <= 16'd4096;
		end else if (cfg.valid) begin
			case (dag_reg_t'(cfg.index))
				REG_MODEL:   model_q <= dag_model_t'(cfg.data[1:0]);
				REG_REF:     ref_q   <= cfg.data[DW-1:0];
				REG_MAX:     max_q   <= cfg.data[DW-1:0];
				REG_ROLLOFF: roll_q  <= cfg.data[15:0];
				default: ;
			endcase
		end
	end

	// global advance, valid line
	assign en           = !vld_q[NV-1] || result.ready;
	assign sample.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NV-2:0], sample.valid};
		end
	end

	// s1: clamp reference and distance, differences
	assign r_c = (ref_q < MINR) ? MINR : ref_q;
	assign d_c = (sample.distance < r_c) ? r_c : sample.distance;

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1      <= r_c;
			d_s1      <= d_c;
			excess_s1 <= d_c - r_c;
			span_s1   <= max_q - r_c;
			left_s1   <= max_q - d_c;
			past_s1   <= (d_c >= max_q);
		end
	end

	// s2: rolloff times excess
	always_ff @(posedge clk) begin
		if (en) begin
			m_s2    <= MW'(roll_q) * MW'(excess_s1);
			r_s2    <= r_s1;
			span_s2 <= span_s1;
			left_s2 <= left_s1;
			past_s2 <= past_s1;
		end
	end

	// s3: divider operands for the selected model and the tail fade
	assign is_lin = (model_q == MODEL_LINEAR);
	assign rq     = AW'({r_s2, 12'h000});
	assign q_lin  = AW'({span_s2, 12'h000});
	assign m_ext  = AW'(m_s2);
	assign b_num  = {left_s2, 2'b00};

	assign flags_c.past  = past_s2;
	assign flags_c.unity = (m_s2 == '0);
	assign flags_c.zero  = (m_ext >= q_lin);

	always_ff @(posedge clk) begin
		if (en) begin
			a_num_s3 <= is_lin ? (q_lin - m_ext) : rq;
			a_den_s3 <= is_lin ? q_lin : (rq + m_ext);
			flags_s3 <= flags_c;
			b_num_s3 <= b_num;
			b_den_s3 <= BW'(span_s2);
			tail_s3  <= (b_num < BW'(span_s2));
		end
	end

	dag_fdiv #(.W(AW), .STEPS(GF), .side_t(dag_flags_t)) u_div_main (
		.clk      (clk),
		.en       (en),
		.num      (a_num_s3),
		.den      (a_den_s3),
		.side     (flags_s3),
		.quo      (qa),
		.side_out (flags_d)
	);

	dag_fdiv #(.W(BW), .STEPS(GF), .side_t(logic)) u_div_tail (
		.clk      (clk),
		.en       (en),
		.num      (b_num_s3),
		.den      (b_den_s3),
		.side     (tail_s3),
		.quo      (tb),
		.side_out (tail_d)
	);

	// d1: special cases, tail fade product, model select
	assign g_pre = (is_lin && flags_d.zero) ? '0 :
	               flags_d.unity ? GONE : GW'(qa);
	assign tail_prod = (GW+GF)'(g_pre) * (GW+GF)'(tb);
	assign g_tail    = tail_prod[GF +: GW];

	always_comb begin
		case (model_q)
			MODEL_NONE:    g_div = GONE;
			MODEL_LINEAR:  g_div = flags_d.past ? '0 : g_pre;
			MODEL_INVERSE: g_div = flags_d.past ? '0 : (tail_d ? g_tail : g_pre);
			default:       g_div = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g_d1       <= g_div;
			use_exp_d1 <= (model_q == MODEL_EXP) && !flags_d.past;
		end
	end

	// align with the exponential path
	always_ff @(posedge clk) begin
		if (en) begin
			g_dl_q[0]   <= g_d1;
			exp_dl_q[0] <= use_exp_d1;
			for (int i = 1; i < DLY; i++) begin
				g_dl_q[i]   <= g_dl_q[i-1];
				exp_dl_q[i] <= exp_dl_q[i-1];
			end
		end
	end

	dag_expo #(.DIST_WIDTH(DW), .GAIN_FRAC(GF)) u_expo (
		.clk      (clk),
		.en       (en),
		.rolloff  (roll_q),
		.dist_val (d_s1),
		.refd     (r_s1),
		.gain     (g_exp)
	);

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			gain_q <= exp_dl_q[DLY-1] ? g_exp : g_dl_q[DLY-1];
		end
	end

	assign gain_x       = XW'(gain_q);
	assign result.gain  = gain_x[15:0];
	assign result.valid = vld_q[NV-1];
endmodule

[sv/dag_fdiv.sv]
// Pipelined restoring fractional divider, one quotient bit per stage.
module dag_fdiv #(
	parameter int W     = 41,
	parameter int STEPS = 15,
	parameter type side_t = logic
) (
	input  logic             clk,
	input  logic             en,
	input  logic [W-1:0]     num,
	input  logic [W-1:0]     den,
	input  side_t            side,
	output logic [STEPS-1:0] quo,
	output side_t            side_out
);
	logic [W-1:0]     rem_s  [STEPS+1];
	logic [W-1:0]     den_s  [STEPS+1];
	logic [STEPS-1:0] quo_s  [STEPS+1];
	side_t            side_s [STEPS+1];

	assign rem_s[0]  = num;
	assign den_s[0]  = den;
	assign quo_s[0]  = '0;
	assign side_s[0] = side;

	for (genvar j = 1; j <= STEPS; j++) begin : g_step
		logic [W:0] shl;
		logic       ge;

		// shift remainder, trial subtract
		assign shl = {rem_s[j-1], 1'b0};
		assign ge  = (shl >= {1'b0, den_s[j-1]});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= ge ? W'(shl - {1'b0, den_s[j-1]}) : shl[W-1:0];
				den_s[j]  <= den_s[j-1];
				quo_s[j]  <= {quo_s[j-1][STEPS-2:0], ge};
				side_s[j] <= side_s[j-1];
			end
		end
	end

	assign quo      = quo_s[STEPS];
	assign side_out = side_s[STEPS];
endmodule

[sv/dag_expo.sv]
// Exponential model path: log2 of distance and reference, scale, exp2, shift.
module dag_expo #(
	parameter int DIST_WIDTH = 24,
	parameter int GAIN_FRAC  = 15
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [15:0]           rolloff,
	input  logic [DIST_WIDTH-1:0] dist_val,
	input  logic [DIST_WIDTH-1:0] refd,
	output logic [GAIN_FRAC:0]    gain
);
	import dag_pkg::*;

	localparam int DW = DIST_WIDTH;
	localparam int GF = GAIN_FRAC;
	localparam int GW = GF + 1;
	localparam int EW = $clog2(DW);
	localparam int LW = EW + LFRAC;
	localparam int PW = 16 + LW;
	localparam int KW = PW - 28;

	logic [DW-1:0] x_in [2];
	logic [EW-1:0] e_c  [2];
	logic [DW-1:0] x_s1 [2];
	logic [EW-1:0] e_s1 [2];

	// log lanes: index 0 is the normalized value
	logic [30:0]      m_lg_s [LFRAC+1][2];
	logic [LFRAC-1:0] f_lg_s [LFRAC+1][2];
	logic [EW-1:0]    e_lg_s [LFRAC+1][2];

	logic [LW-1:0] ld;
	logic [LW-1:0] lr;
	logic [LW-1:0] l_s;
	logic [PW-1:0] scale;

	// exp chain: index 0 is the scaled exponent
	logic [30:0]      p_ex_s  [LFRAC+1];
	logic [LFRAC-1:0] fr_ex_s [LFRAC+1];
	logic [KW-1:0]    k_ex_s  [LFRAC+1];

	logic [9:0]    sh;
	logic [GW-1:0] gain_q;

	assign x_in[0] = dist_val;
	assign x_in[1] = refd;

	// leading one position
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			e_c[l] = '0;
			for (int i = 0; i < DW; i++) begin
				if (x_in[l][i]) begin
					e_c[l] = EW'(i);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 2; l++) begin
				x_s1[l] <= x_in[l];
				e_s1[l] <= e_c[l];
			end
		end
	end

	// normalize mantissa to Q1.30
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 2; l++) begin
				m_lg_s[0][l] <= 31'(({x_s1[l], 30'b0}) >> e_s1[l]);
				e_lg_s[0][l] <= e_s1[l];
				f_lg_s[0][l] <= '0;
			end
		end
	end

	// one fraction bit per stage: square, compare against two
	for (genvar j = 1; j <= LFRAC; j++) begin : g_log
		logic [61:0] sq [2];

		always_comb begin
			for (int l = 0; l < 2; l++) begin
				sq[l] = 62'(m_lg_s[j-1][l]) * 62'(m_lg_s[j-1][l]);
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < 2; l++) begin
					m_lg_s[j][l] <= sq[l][61] ? sq[l][61:31] : sq[l][60:30];
					f_lg_s[j][l] <= {f_lg_s[j-1][l][LFRAC-2:0], sq[l][61]};
					e_lg_s[j][l] <= e_lg_s[j-1][l];
				end
			end
		end
	end

	// log difference, clipped at zero
	assign ld = {e_lg_s[LFRAC][0], f_lg_s[LFRAC][0]};
	assign lr = {e_lg_s[LFRAC][1], f_lg_s[LFRAC][1]};

	always_ff @(posedge clk) begin
		if (en) begin
			l_s <= (ld > lr) ? (ld - lr) : '0;
		end
	end

	// scale by rolloff, Q4.12
	assign scale = PW'(rolloff) * PW'(l_s);

	always_ff @(posedge clk) begin
		if (en) begin
			p_ex_s[0]  <= 31'h4000_0000;
			fr_ex_s[0] <= scale[27:12];
			k_ex_s[0]  <= scale[PW-1:28];
		end
	end

	// 2^-frac as a product of root constants, top fraction bit first
	for (genvar j = 1; j <= LFRAC; j++) begin : g_exp
		localparam logic [29:0] CJ = exp_const(j - 1);
		logic [60:0] pr;

		assign pr = 61'(p_ex_s[j-1]) * 61'(CJ);

		always_ff @(posedge clk) begin
			if (en) begin
				p_ex_s[j]  <= fr_ex_s[j-1][LFRAC-j] ? pr[60:30] : p_ex_s[j-1];
				fr_ex_s[j] <= fr_ex_s[j-1];
				k_ex_s[j]  <= k_ex_s[j-1];
			end
		end
	end

	// integer part of the exponent as a right shift
	assign sh = 10'(30 - GF) + 10'(k_ex_s[LFRAC]);

	always_ff @(posedge clk) begin
		if (en) begin
			gain_q <= (sh > 10'd30) ? '0 : GW'(p_ex_s[LFRAC] >> sh[4:0]);
		end
	end

	assign gain = gain_q;
endmodule

[test/dag_gain_checker.sv]
// Checker for the distance attenuation gain block: mirrors registers, predicts and compares gains.
`timescale 1ns / 100ps

module dag_gain_checker (
	input  logic clk,
	input  logic arst_n,
	dag_cfg_if   cfg,
	dag_dist_if  sample,
	dag_gain_if  result,
	output int   fails,
	output int   pending,
	output int   gains_seen
);
	import dag_pkg::*;

	localparam int        GFRAC    = 15;
	localparam logic [63:0] UNITY  = 64'd1 << GFRAC;
	localparam logic [63:0] Q30    = 64'd1 << 30;

	// mirrored configuration
	dag_model_t  model;
	logic [23:0] ref_dist;
	logic [23:0] max_dist;
	logic [15:0] rolloff;

	logic [15:0] gain_queue[$];

	// bit-serial integer square root
	function automatic logic [63:0] int_sqrt(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] root;
		logic [63:0] bitv;
		v = v_in;
		root = '0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v = v - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	// floor(num * 2^nbits / den), num < den
	function automatic logic [63:0] scaled_ratio(input logic [63:0] num, input logic [63:0] den,
		input int nbits);
		logic [63:0] n;
		logic [63:0] q;
		n = num;
		q = '0;
		for (int i = 0; i < nbits; i++) begin
			n = n << 1;
			q = q << 1;
			if (n >= den) begin
				n = n - den;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	// log2 in Q5.16 by square-and-compare
	function automatic logic [63:0] log2_q16(input logic [63:0] x);
		int          msb;
		logic [63:0] m;
		logic [63:0] acc;
		msb = 0;
		while (msb < 63 && (x >> (msb + 1)) != 0)
			msb++;
		m = (msb <= 30) ? (x << (30 - msb)) : (x >> (msb - 30));
		acc = 64'(msb) << 16;
		for (int i = 15; i >= 0; i--) begin
			m = (m * m) >> 30;
			if (m >= (Q30 << 1)) begin
				m = m >> 1;
				acc[i] = 1'b1;
			end
		end
		return acc;
	endfunction

	// (d/r)^-rolloff via log2 difference and exp2 product
	function automatic logic [63:0] power_falloff(input logic [63:0] d, input logic [63:0] r);
		logic [63:0] ld;
		logic [63:0] lr;
		logic [63:0] diff;
		logic [63:0] ex;
		logic [63:0] whole;
		logic [63:0] prod;
		logic [63:0] c;
		logic [63:0] sh;
		ld = log2_q16(d);
		lr = log2_q16(r);
		diff = (ld > lr) ? ld - lr : 64'd0;
		ex = (64'(rolloff) * diff) >> 12;
		whole = ex >> 16;
		prod = Q30;
		c = int_sqrt(64'd1 << 59);
		for (int i = 15; i >= 0; i--) begin
			if (ex[i])
				prod = (prod * c) >> 30;
			c = int_sqrt(c << 30);
		end
		sh = 64'(30 - GFRAC) + whole;
		if (sh >= 64)
			return 64'd0;
		return prod >> sh;
	endfunction

	// expected gain of one distance under the mirrored configuration
	function automatic logic [15:0] attenuation(input logic [23:0] dist_in);
		logic [63:0] r;
		logic [63:0] d;
		logic [63:0] mx;
		logic [63:0] g;
		logic [63:0] span;
		logic [63:0] excess;
		logic [63:0] n;
		logic [63:0] q;
		logic [63:0] left;
		logic [63:0] t;
		r = 64'(ref_dist);
		d = 64'(dist_in);
		mx = 64'(max_dist);
		if (r < 1)
			r = 1;
		if (d < r)
			d = r;
		if (model == MODEL_NONE) begin
			g = UNITY;
		end else if (d >= mx) begin
			g = 0;
		end else begin
			span = mx - r;
			excess = d - r;
			case (model)
				MODEL_LINEAR: begin
					n = 64'(rolloff) * excess;
					q = span * 4096;
					if (n >= q)
						g = 0;
					else if (n == 0)
						g = UNITY;
					else
						g = scaled_ratio(q - n, q, GFRAC);
				end
				MODEL_INVERSE: begin
					n = r * 4096;
					q = n + 64'(rolloff) * excess;
					left = mx - d;
					g = (n >= q) ? UNITY : scaled_ratio(n, q, GFRAC);
					// linear fade over the last quarter of the range
					if (4 * left < span) begin
						t = scaled_ratio(4 * left, span, GFRAC);
						g = (g * t) >> GFRAC;
					end
				end
				default: g = power_falloff(d, r);
			endcase
		end
		if (g > UNITY)
			g = UNITY;
		return g[15:0];
	endfunction

	assign pending = gain_queue.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model <= MODEL_INVERSE;
			ref_dist <= 24'd256;
			max_dist <= 24'hFFFFFF;
			rolloff <= 16'd4096;
			fails <= 0;
			gains_seen <= 0;
			gain_queue.delete();
		end else begin
			// register writes
			if (cfg.valid && cfg.ready) begin
				case (dag_reg_t'(cfg.index))
					REG_MODEL:   model <= dag_model_t'(cfg.data[1:0]);
					REG_REF:     ref_dist <= cfg.data[23:0];
					REG_MAX:     max_dist <= cfg.data[23:0];
					REG_ROLLOFF: rolloff <= cfg.data[15:0];
					default: ;
				endcase
			end
			// accepted distance request
			if (sample.valid && sample.ready)
				gain_queue.push_back(attenuation(sample.distance));
			// returned gain
			if (result.valid && result.ready) begin
				gains_seen <= gains_seen + 1;
				if (gain_queue.size() == 0) begin
					$error("unexpected gain %0d with nothing outstanding", result.gain);
					fails <= fails + 1;
				end else begin
					if (result.gain !== gain_queue[0]) begin
						$error("gain mismatch: expected %0d actual %0d",
							gain_queue[0], result.gain);
						fails <= fails + 1;
					end
					void'(gain_queue.pop_front());
				end
			end
		end
	end
endmodule

[test/tb_distance_attenuation_gain.sv]
// Testbench top for the distance attenuation gain block: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_distance_attenuation_gain;
	import dag_pkg::*;

	logic clk;
	logic arst_n;

	dag_cfg_if #(.DATA_W(24)) cfg_if ();
	dag_dist_if #(.DIST_W(24)) dist_if ();
	dag_gain_if res_if ();

	int fails;
	int pending;
	int gains_seen;
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_req;
	int requests_sent;
	int reg_writes;

	logic [23:0] cur_ref;
	logic [23:0] cur_max;

	distance_attenuation_gain u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_if),
		.sample (dist_if),
		.result (res_if)
	);

	dag_gain_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_if),
		.sample     (dist_if),
		.result     (res_if),
		.fails      (fails),
		.pending    (pending),
		.gains_seen (gains_seen)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard limit
	initial begin
		#30_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// result side flow control, with a long hold-off on request
	initial begin
		res_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				res_if.ready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_req = 1'b0;
			end
			res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// one distance request
	task automatic send_dist(input logic [23:0] d);
		while ($urandom_range(99) < send_idle_pct) begin
			dist_if.valid <= 1'b0;
			@(posedge clk);
		end
		dist_if.valid <= 1'b1;
		dist_if.distance <= d;
		@(posedge clk);
		while (!dist_if.ready)
			@(posedge clk);
		requests_sent++;
	endtask

	task automatic write_reg(input dag_reg_t idx, input logic [23:0] val);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= val;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		cfg_if.valid <= 1'b0;
		@(posedge clk);
		reg_writes++;
	endtask

	// drain all outstanding gains
	task automatic drain();
		dist_if.valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (50) @(posedge clk);
	endtask

	task automatic configure(input dag_model_t m, input logic [23:0] r, input logic [23:0] mx,
		input logic [15:0] ro);
		write_reg(REG_MODEL, 24'(m));
		write_reg(REG_REF, r);
		write_reg(REG_MAX, mx);
		write_reg(REG_ROLLOFF, 24'(ro));
		cur_ref = r;
		cur_max = mx;
	endtask

	// distance biased toward the interesting parts of [ref, max]
	function automatic logic [23:0] pick_dist();
		logic [23:0] lo;
		logic [23:0] hi;
		lo = cur_ref;
		hi = cur_max;
		if (hi < lo) begin
			lo = cur_max;
			hi = cur_ref;
		end
		case ($urandom_range(4))
			0: return 24'($urandom);
			1: return 24'($urandom_range(hi, lo));
			2: return 24'($urandom_range(hi, hi - ((hi - lo) >> 2)));
			3: return 24'($urandom_range(255));
			default: return 24'(lo + $urandom_range(7)) - 24'd3;
		endcase
	endfunction

	initial begin
		dag_model_t  m;
		logic [23:0] r;
		logic [23:0] mx;
		logic [15:0] ro;

		cfg_if.valid = 1'b0;
		cfg_if.index = REG_MODEL;
		cfg_if.data = '0;
		dist_if.valid = 1'b0;
		dist_if.distance = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req = 1'b0;
		requests_sent = 0;
		reg_writes = 0;
		cur_ref = 24'd256;
		cur_max = 24'hFFFFFF;
		#1 arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, field extremes, ref and max edges
		send_dist(24'd0);
		send_dist(24'd256);
		send_dist(24'd257);
		send_dist(24'd4096);
		send_dist(24'hFFFFFE);
		send_dist(24'hFFFFFF);
		send_dist(24'hAAAAAA);
		send_dist(24'h555555);
		drain();
		// each model, zero reference, zero rolloff, max at or below ref
		configure(MODEL_NONE, 24'd0, 24'd0, 16'd0);
		send_dist(24'd0);
		send_dist(24'hFFFFFF);
		drain();
		configure(MODEL_LINEAR, 24'd0, 24'd1000, 16'hFFFF);
		send_dist(24'd0);
		send_dist(24'd1);
		send_dist(24'd999);
		send_dist(24'd1000);
		drain();
		configure(MODEL_INVERSE, 24'd512, 24'd2048, 16'd0);
		send_dist(24'd600);
		send_dist(24'd2000);
		drain();
		configure(MODEL_EXP, 24'hFFFFFF, 24'd100, 16'hFFFF);
		send_dist(24'd50);
		send_dist(24'hFFFFFF);
		drain();
		configure(MODEL_EXP, 24'd1, 24'hFFFFFF, 16'hFFFF);
		send_dist(24'd2);
		send_dist(24'hFFFFFE);
		drain();

		// random phases: settings and idling vary per phase
		for (int ph = 0; ph < 16; ph++) begin
			m = dag_model_t'(ph % 4);
			case (ph % 5)
				0: r = 24'd0;
				1: r = 24'd256;
				2: r = 24'hFFFFFF;
				default: r = 24'($urandom_range(65535));
			endcase
			case (ph % 3)
				0: mx = 24'hFFFFFF;
				1: mx = 24'($urandom);
				default: mx = r + 24'($urandom_range(4095));
			endcase
			case (ph % 4)
				0: ro = 16'd0;
				1: ro = 16'hFFFF;
				default: ro = 16'($urandom);
			endcase
			configure(m, r, mx, ro);
			case ((ph / 4) % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
				default: begin send_idle_pct = 7; recv_stall_pct = 7; end
			endcase
			if (ph == 5)
				hold_req = 1'b1;
			for (int k = 0; k < 80; k++)
				send_dist(pick_dist());
			// sender pauses until every gain is back
			drain();
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		drain();
		$display("covered %0d distance requests, %0d gains, %0d register writes",
			requests_sent, gains_seen, reg_writes);
		$display("all four models under flow-control stress and register extremes");
		if (fails == 0 && pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule

[distance_attenuation_gain.f]
sv/dag_pkg.sv
sv/dag_cfg_if.sv
sv/dag_dist_if.sv
sv/dag_gain_if.sv
sv/dag_fdiv.sv
sv/dag_expo.sv
sv/distance_attenuation_gain.sv
test/dag_gain_checker.sv
test/tb_distance_attenuation_gain.sv
